FILE: rtl/tra_pkg.sv
package tra_pkg;

	// default position fraction width
	localparam int POS_FRAC_BITS_DEF = 4;

	// field widths
	localparam int TYPE_W  = 5;
	localparam int CODE_W  = 10;
	localparam int VALUE_W = 32;
	localparam int CFG_W   = 16;
	localparam int SCR_W   = 12;
	localparam int OUT_W   = 16;

	// pressure scaling: Q1.15, full scale 1.0
	localparam int                PRESS_W    = 16;
	localparam logic [PRESS_W-1:0] PRESS_FULL = 16'h8000;

	// event types
	localparam logic [TYPE_W-1:0] EV_SYN = 5'd0;
	localparam logic [TYPE_W-1:0] EV_KEY = 5'd1;
	localparam logic [TYPE_W-1:0] EV_ABS = 5'd3;
	localparam logic [TYPE_W-1:0] PREV_TYPE_RST = 5'd31;

	// event codes
	localparam logic [CODE_W-1:0] CODE_SYN_REPORT     = 10'd0;
	localparam logic [CODE_W-1:0] CODE_ABS_X          = 10'd0;
	localparam logic [CODE_W-1:0] CODE_ABS_Y          = 10'd1;
	localparam logic [CODE_W-1:0] CODE_ABS_PRESSURE   = 10'd24;
	localparam logic [CODE_W-1:0] CODE_BTN_TOOL_PEN   = 10'd320;
	localparam logic [CODE_W-1:0] CODE_BTN_TOOL_RUBBER = 10'd321;
	localparam logic [CODE_W-1:0] CODE_BTN_TOUCH      = 10'd330;

	// report kinds
	localparam logic [1:0] KIND_ENTER = 2'd0;
	localparam logic [1:0] KIND_PEN   = 2'd1;
	localparam logic [1:0] KIND_LEAVE = 2'd2;

	// tools
	localparam logic [1:0] TOOL_NONE   = 2'd0;
	localparam logic [1:0] TOOL_PEN    = 2'd1;
	localparam logic [1:0] TOOL_ERASER = 2'd2;

	// register indexes
	localparam logic [2:0] REG_X_MIN  = 3'd0;
	localparam logic [2:0] REG_X_MAX  = 3'd1;
	localparam logic [2:0] REG_Y_MIN  = 3'd2;
	localparam logic [2:0] REG_Y_MAX  = 3'd3;
	localparam logic [2:0] REG_P_MIN  = 3'd4;
	localparam logic [2:0] REG_P_MAX  = 3'd5;
	localparam logic [2:0] REG_SCR_W  = 3'd6;
	localparam logic [2:0] REG_SCR_H  = 3'd7;

	// register reset values
	localparam logic [CFG_W-1:0] X_MIN_RST = 16'd0;
	localparam logic [CFG_W-1:0] X_MAX_RST = 16'd20967;
	localparam logic [CFG_W-1:0] Y_MIN_RST = 16'd0;
	localparam logic [CFG_W-1:0] Y_MAX_RST = 16'd15725;
	localparam logic [CFG_W-1:0] P_MIN_RST = 16'd0;
	localparam logic [CFG_W-1:0] P_MAX_RST = 16'd4095;
	localparam logic [SCR_W-1:0] SCR_W_RST = 12'd1404;
	localparam logic [SCR_W-1:0] SCR_H_RST = 12'd1872;

endpackage

FILE: rtl/tra_scale.sv
module tra_scale #(
	parameter int FULL_W = tra_pkg::PRESS_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         raw,
	input  logic [15:0]         lo,
	input  logic [15:0]         hi,
	input  logic [FULL_W-1:0]   full,
	output logic                busy,
	output logic [15:0]         result
);

	localparam int CNT_W = $clog2(FULL_W + 1);
	localparam int EXT_W = (FULL_W > 16) ? FULL_W : 17;

	typedef enum logic [1:0] {SC_IDLE, SC_PREP, SC_CHK, SC_RUN} sc_state_t;

	sc_state_t          state_q;
	logic [32:0]        num_q;
	logic [16:0]        rng_q;
	logic [32:0]        an_q;
	logic [15:0]        ar_q;
	logic [16:0]        ar2_q;
	logic               skip_q;
	logic [FULL_W-1:0]  full_q;
	logic [15:0]        rem_q;
	logic [FULL_W-1:0]  quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [15:0]        result_q;

	logic [32:0]        num_d;
	logic [16:0]        rng_d;
	logic [32:0]        num_abs;
	logic [16:0]        rng_abs;
	logic [17:0]        tsum;
	logic [18:0]        d1;
	logic [18:0]        d2;
	logic [15:0]        rem_n;
	logic [1:0]         qdig;
	logic [FULL_W:0]    quo_w;

	// clamp to 16 bits
	function automatic logic [15:0] sat16(input logic [FULL_W-1:0] v);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(v);
		return (|ext[EXT_W-1:16]) ? 16'hFFFF : ext[15:0];
	endfunction

	// offset from minimum and axis span
	assign num_d = {raw[31], raw} - {{17{lo[15]}}, lo};
	assign rng_d = {hi[15], hi} - {lo[15], lo};

	// magnitudes
	assign num_abs = num_q[32] ? (~num_q + 33'd1) : num_q;
	assign rng_abs = rng_q[16] ? (~rng_q + 17'd1) : rng_q;

	// one multiplier bit per cycle: remainder doubles, adds numerator, drops ar up to twice
	assign tsum  = {1'b0, rem_q, 1'b0} + (full_q[FULL_W-1] ? {2'b00, an_q[15:0]} : 18'd0);
	assign d1    = {1'b0, tsum} - {3'b000, ar_q};
	assign d2    = {1'b0, tsum} - {2'b00, ar2_q};

	always_comb begin
		if (!d2[18]) begin
			rem_n = d2[15:0];
			qdig  = 2'd2;
		end else if (!d1[18]) begin
			rem_n = d1[15:0];
			qdig  = 2'd1;
		end else begin
			rem_n = tsum[15:0];
			qdig  = 2'd0;
		end
	end

	assign quo_w = {quo_q, 1'b0} + (FULL_W + 1)'(qdig);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				SC_IDLE: begin
					if (start) begin
						num_q   <= num_d;
						rng_q   <= rng_d;
						full_q  <= full;
						state_q <= SC_PREP;
					end
				end
				SC_PREP: begin
					skip_q  <= (rng_q == 17'd0) || (num_q == 33'd0) || (num_q[32] != rng_q[16]);
					an_q    <= num_abs;
					ar_q    <= rng_abs[15:0];
					ar2_q   <= {rng_abs[15:0], 1'b0};
					state_q <= SC_CHK;
				end
				SC_CHK: begin
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= '0;
					if (skip_q) begin
						result_q <= 16'd0;
						state_q  <= SC_IDLE;
					end else if (an_q >= {17'd0, ar_q}) begin
						// ratio at least one: saturate to full scale
						result_q <= sat16(full_q);
						state_q  <= SC_IDLE;
					end else begin
						state_q <= SC_RUN;
					end
				end
				SC_RUN: begin
					rem_q  <= rem_n;
					quo_q  <= quo_w[FULL_W-1:0];
					full_q <= {full_q[FULL_W-2:0], 1'b0};
					cnt_q  <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(FULL_W - 1)) begin
						result_q <= sat16(quo_w[FULL_W-1:0]);
						state_q  <= SC_IDLE;
					end
				end
				default: state_q <= SC_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != SC_IDLE);
	assign result = result_q;

endmodule

FILE: rtl/tablet_report_assembler.sv
// Channel   Direction  Handshake                  Word
// event     in         event_valid/event_ready    event_type, event_code, event_value
// report    out        report_valid/report_ready  kind, tool, pos_x/y, pressure, flags
// config    in         APB psel/penable/pready    8 registers at 4*index
//
// Key, axis and ignored events are taken in the idle state. A sync report runs
// three bit-serial scale lanes in parallel, one multiplier bit per cycle, and
// then delivers each pending result as one report word. Reset clears pen state
// and loads the register defaults. A stalled report holds the assembler in its
// emit phase while further results are pending, and the event input waits
// meanwhile.
module tablet_report_assembler #(
	parameter int POS_FRAC_BITS = tra_pkg::POS_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// event input
	input  logic        event_valid,
	output logic        event_ready,
	input  logic [4:0]  event_type,
	input  logic [9:0]  event_code,
	input  logic [31:0] event_value,
	// report output
	output logic        report_valid,
	input  logic        report_ready,
	output logic [1:0]  report_kind,
	output logic [1:0]  tool_kind,
	output logic [15:0] pos_x,
	output logic [15:0] pos_y,
	output logic [15:0] pressure_level,
	output logic        button_down,
	output logic        last_of_run,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int POS_W = tra_pkg::SCR_W + POS_FRAC_BITS;

	typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_EMIT} state_t;

	state_t       state_q;

	// configuration registers
	logic [15:0]  x_min_q, x_max_q, y_min_q, y_max_q, p_min_q, p_max_q;
	logic [11:0]  scr_w_q, scr_h_q;

	// pen state
	logic [31:0]  raw_x_q, raw_y_q, raw_p_q;
	logic         pen_down_q;
	logic [1:0]   cur_tool_q;
	logic         rep_down_q;
	logic [1:0]   rep_tool_q;
	logic [15:0]  rep_x_q, rep_y_q;
	logic [4:0]   prev_type_q;
	logic         p_empty_q;

	// pending results: enter, pen, leave
	logic [2:0]   mask_q;
	logic [1:0]   pen_tool_q;
	logic [15:0]  pen_x_q, pen_y_q, pen_p_q;
	logic         pen_btn_q;

	logic         ev_acc;
	logic         is_sync;
	logic         start;
	logic [2:0]   reg_idx;
	logic         cfg_wr;
	logic [POS_W-1:0] full_x, full_y;
	logic         busy_x, busy_y, busy_p;
	logic [15:0]  res_x, res_y, res_p;
	logic         lift;
	logic [15:0]  px, py, pr;
	logic [2:0]   mask_d;
	logic [2:0]   mask_n;
	logic         slot_free;

	assign event_ready = (state_q == ST_IDLE);
	assign ev_acc      = event_valid && event_ready;
	assign is_sync     = (event_type == tra_pkg::EV_SYN) &&
	                     (event_code == tra_pkg::CODE_SYN_REPORT) &&
	                     (prev_type_q != tra_pkg::EV_SYN);
	assign start       = ev_acc && is_sync;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// register read
	always_comb begin
		case (reg_idx)
			tra_pkg::REG_X_MIN: prdata = {16'd0, x_min_q};
			tra_pkg::REG_X_MAX: prdata = {16'd0, x_max_q};
			tra_pkg::REG_Y_MIN: prdata = {16'd0, y_min_q};
			tra_pkg::REG_Y_MAX: prdata = {16'd0, y_max_q};
			tra_pkg::REG_P_MIN: prdata = {16'd0, p_min_q};
			tra_pkg::REG_P_MAX: prdata = {16'd0, p_max_q};
			tra_pkg::REG_SCR_W: prdata = {20'd0, scr_w_q};
			tra_pkg::REG_SCR_H: prdata = {20'd0, scr_h_q};
			default:            prdata = 32'd0;
		endcase
	end

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= tra_pkg::X_MIN_RST;
			x_max_q <= tra_pkg::X_MAX_RST;
			y_min_q <= tra_pkg::Y_MIN_RST;
			y_max_q <= tra_pkg::Y_MAX_RST;
			p_min_q <= tra_pkg::P_MIN_RST;
			p_max_q <= tra_pkg::P_MAX_RST;
			scr_w_q <= tra_pkg::SCR_W_RST;
			scr_h_q <= tra_pkg::SCR_H_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				tra_pkg::REG_X_MIN: x_min_q <= pwdata[15:0];
				tra_pkg::REG_X_MAX: x_max_q <= pwdata[15:0];
				tra_pkg::REG_Y_MIN: y_min_q <= pwdata[15:0];
				tra_pkg::REG_Y_MAX: y_max_q <= pwdata[15:0];
				tra_pkg::REG_P_MIN: p_min_q <= pwdata[15:0];
				tra_pkg::REG_P_MAX: p_max_q <= pwdata[15:0];
				tra_pkg::REG_SCR_W: scr_w_q <= pwdata[11:0];
				tra_pkg::REG_SCR_H: scr_h_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	// scale lanes
	assign full_x = POS_W'(scr_w_q) << POS_FRAC_BITS;
	assign full_y = POS_W'(scr_h_q) << POS_FRAC_BITS;

	tra_scale #(.FULL_W(POS_W)) u_scale_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.raw    (raw_x_q),
		.lo     (x_min_q),
		.hi     (x_max_q),
		.full   (full_x),
		.busy   (busy_x),
		.result (res_x)
	);

	tra_scale #(.FULL_W(POS_W)) u_scale_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.raw    (raw_y_q),
		.lo     (y_min_q),
		.hi     (y_max_q),
		.full   (full_y),
		.busy   (busy_y),
		.result (res_y)
	);

	tra_scale #(.FULL_W(tra_pkg::PRESS_W)) u_scale_p (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.raw    (raw_p_q),
		.lo     (p_min_q),
		.hi     (p_max_q),
		.full   (tra_pkg::PRESS_FULL),
		.busy   (busy_p),
		.result (res_p)
	);

	// pick the pen report data, repeating the held position on lift-off
	assign lift = !pen_down_q && rep_down_q;
	assign px   = lift ? rep_x_q : res_x;
	assign py   = lift ? rep_y_q : res_y;
	assign pr   = p_empty_q ? tra_pkg::PRESS_FULL : res_p;

	assign mask_d[0] = (rep_tool_q == tra_pkg::TOOL_NONE) && (cur_tool_q != tra_pkg::TOOL_NONE);
	assign mask_d[1] = pen_down_q || rep_down_q;
	assign mask_d[2] = (rep_tool_q != tra_pkg::TOOL_NONE) && (cur_tool_q == tra_pkg::TOOL_NONE);

	// drop the lowest pending result
	assign mask_n    = mask_q & (mask_q - 3'd1);
	assign slot_free = !report_valid || report_ready;

	// event handling, report sequencing and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			raw_x_q      <= '0;
			raw_y_q      <= '0;
			raw_p_q      <= '0;
			pen_down_q   <= 1'b0;
			cur_tool_q   <= tra_pkg::TOOL_NONE;
			rep_down_q   <= 1'b0;
			rep_tool_q   <= tra_pkg::TOOL_NONE;
			rep_x_q      <= '0;
			rep_y_q      <= '0;
			prev_type_q  <= tra_pkg::PREV_TYPE_RST;
			mask_q       <= '0;
			report_valid <= 1'b0;
		end else begin
			// release a taken word outside the emit phase
			if (report_ready && (state_q != ST_EMIT)) begin
				report_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (ev_acc) begin
						prev_type_q <= event_type;
						if (event_type == tra_pkg::EV_ABS) begin
							if (event_code == tra_pkg::CODE_ABS_X) begin
								raw_x_q <= event_value;
							end else if (event_code == tra_pkg::CODE_ABS_Y) begin
								raw_y_q <= event_value;
							end else if (event_code == tra_pkg::CODE_ABS_PRESSURE) begin
								raw_p_q <= event_value;
							end
						end else if (event_type == tra_pkg::EV_KEY) begin
							if (event_code == tra_pkg::CODE_BTN_TOUCH) begin
								pen_down_q <= (event_value != 32'd0);
							end else if (event_code == tra_pkg::CODE_BTN_TOOL_PEN) begin
								cur_tool_q <= (event_value != 32'd0) ?
								              tra_pkg::TOOL_PEN : tra_pkg::TOOL_NONE;
							end else if (event_code == tra_pkg::CODE_BTN_TOOL_RUBBER) begin
								cur_tool_q <= (event_value != 32'd0) ?
								              tra_pkg::TOOL_ERASER : tra_pkg::TOOL_NONE;
							end
						end else if (is_sync) begin
							p_empty_q <= (p_max_q == p_min_q);
							state_q   <= ST_CALC;
						end
					end
				end
				ST_CALC: begin
					if (!busy_x && !busy_y && !busy_p) begin
						pen_tool_q <= lift ? rep_tool_q : cur_tool_q;
						pen_x_q    <= px;
						pen_y_q    <= py;
						pen_p_q    <= pr;
						pen_btn_q  <= pen_down_q;
						mask_q     <= mask_d;
						rep_down_q <= pen_down_q;
						rep_tool_q <= cur_tool_q;
						rep_x_q    <= px;
						rep_y_q    <= py;
						state_q    <= (mask_d != 3'd0) ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						report_valid <= 1'b1;
						last_of_run  <= (mask_n == 3'd0);
						if (mask_q[0]) begin
							report_kind    <= tra_pkg::KIND_ENTER;
							tool_kind      <= cur_tool_q;
							pos_x          <= '0;
							pos_y          <= '0;
							pressure_level <= '0;
							button_down    <= 1'b0;
						end else if (mask_q[1]) begin
							report_kind    <= tra_pkg::KIND_PEN;
							tool_kind      <= pen_tool_q;
							pos_x          <= pen_x_q;
							pos_y          <= pen_y_q;
							pressure_level <= pen_p_q;
							button_down    <= pen_btn_q;
						end else begin
							report_kind    <= tra_pkg::KIND_LEAVE;
							tool_kind      <= cur_tool_q;
							pos_x          <= '0;
							pos_y          <= '0;
							pressure_level <= '0;
							button_down    <= 1'b0;
						end
						mask_q <= mask_n;
						if (mask_n == 3'd0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: dv/tablet_report_assembler_tb.sv
module tablet_report_assembler_tb;

	localparam int FRAC          = tra_pkg::POS_FRAC_BITS_DEF;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 400000;

	// codes the block has no use for
	localparam logic [tra_pkg::TYPE_W-1:0] EV_OTHER          = 5'd2;
	localparam logic [tra_pkg::TYPE_W-1:0] EV_TOP            = 5'd31;
	localparam logic [tra_pkg::CODE_W-1:0] CODE_ABS_DISTANCE = 10'd25;
	localparam logic [tra_pkg::CODE_W-1:0] CODE_UNUSED       = 10'd767;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  tool;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] press;
		logic        down;
		logic        last;
	} report_t;

	typedef struct packed {
		logic [4:0]  et;
		logic [9:0]  ec;
		logic [31:0] ev;
		bit          typed;
		logic [1:0]  cnt;
		report_t     first;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        event_valid;
	logic        event_ready;
	logic [4:0]  event_type;
	logic [9:0]  event_code;
	logic [31:0] event_value;
	logic        report_valid;
	logic        report_ready;
	logic [1:0]  report_kind;
	logic [1:0]  tool_kind;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [15:0] pressure_level;
	logic        button_down;
	logic        last_of_run;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tablet_report_assembler #(.POS_FRAC_BITS(FRAC)) uut (
		.clk(clk), .arst_n(arst_n),
		.event_valid(event_valid), .event_ready(event_ready),
		.event_type(event_type), .event_code(event_code), .event_value(event_value),
		.report_valid(report_valid), .report_ready(report_ready),
		.report_kind(report_kind), .tool_kind(tool_kind),
		.pos_x(pos_x), .pos_y(pos_y), .pressure_level(pressure_level),
		.button_down(button_down), .last_of_run(last_of_run),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #4 clk = ~clk;

	// register shadow and pen state of the predictor
	logic [15:0] cfg_reg [8];
	logic [31:0] pen_x_raw, pen_y_raw, pen_p_raw;
	logic        touch_now, touch_sent;
	logic [1:0]  tool_now, tool_sent;
	logic [15:0] sent_x, sent_y;
	logic [4:0]  last_type;

	report_t burst [3];
	report_t pending_reports [$];
	int      mismatches = 0;
	int      send_idle_pct = 0;
	int      stall_pct = 0;

	task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
		$display("MISMATCH %s: expected %0h, got %0h", what, want, got);
		mismatches++;
	endtask

	function automatic report_t make_report(logic [1:0] kind, logic [1:0] tool,
			logic [15:0] x, logic [15:0] y, logic [15:0] p, logic down, logic last);
		report_t r;
		r.kind  = kind;
		r.tool  = tool;
		r.x     = x;
		r.y     = y;
		r.press = p;
		r.down  = down;
		r.last  = last;
		return r;
	endfunction

	// num * full / span, truncated, clamped to 0..full and to 16 bits
	function automatic logic [15:0] scale_axis(longint num, longint span, longint full);
		longint an, ar, q;
		if (span == 0 || num == 0) return 16'd0;
		if ((num < 0) != (span < 0)) return 16'd0;
		an = (num < 0) ? -num : num;
		ar = (span < 0) ? -span : span;
		q = an * full / ar;
		if (q > full) q = full;
		if (q > 65535) q = 65535;
		return q[15:0];
	endfunction

	// update pen state for one event word and queue the reports it causes
	function automatic int assemble_reports(logic [4:0] et, logic [9:0] ec, logic [31:0] ev);
		int          n;
		longint      xmn, xmx, ymn, ymx, pmn, pmx;
		logic [15:0] px, py, pr;
		logic [1:0]  tool;
		n = 0;
		if (et == tra_pkg::EV_ABS) begin
			if (ec == tra_pkg::CODE_ABS_X) pen_x_raw = ev;
			else if (ec == tra_pkg::CODE_ABS_Y) pen_y_raw = ev;
			else if (ec == tra_pkg::CODE_ABS_PRESSURE) pen_p_raw = ev;
		end else if (et == tra_pkg::EV_KEY) begin
			if (ec == tra_pkg::CODE_BTN_TOUCH) touch_now = (ev != 0);
			else if (ec == tra_pkg::CODE_BTN_TOOL_PEN)
				tool_now = (ev != 0) ? tra_pkg::TOOL_PEN : tra_pkg::TOOL_NONE;
			else if (ec == tra_pkg::CODE_BTN_TOOL_RUBBER)
				tool_now = (ev != 0) ? tra_pkg::TOOL_ERASER : tra_pkg::TOOL_NONE;
		end else if (et == tra_pkg::EV_SYN && ec == tra_pkg::CODE_SYN_REPORT &&
				last_type != tra_pkg::EV_SYN) begin
			xmn = longint'($signed(cfg_reg[tra_pkg::REG_X_MIN]));
			xmx = longint'($signed(cfg_reg[tra_pkg::REG_X_MAX]));
			ymn = longint'($signed(cfg_reg[tra_pkg::REG_Y_MIN]));
			ymx = longint'($signed(cfg_reg[tra_pkg::REG_Y_MAX]));
			pmn = longint'($signed(cfg_reg[tra_pkg::REG_P_MIN]));
			pmx = longint'($signed(cfg_reg[tra_pkg::REG_P_MAX]));
			tool = tool_now;
			if (tool_sent == tra_pkg::TOOL_NONE && tool_now != tra_pkg::TOOL_NONE) begin
				burst[n] = make_report(tra_pkg::KIND_ENTER, tool_now, 16'd0, 16'd0, 16'd0,
					1'b0, 1'b0);
				n++;
			end
			px = scale_axis(longint'($signed(pen_x_raw)) - xmn, xmx - xmn,
				longint'(cfg_reg[tra_pkg::REG_SCR_W][11:0]) << FRAC);
			py = scale_axis(longint'($signed(pen_y_raw)) - ymn, ymx - ymn,
				longint'(cfg_reg[tra_pkg::REG_SCR_H][11:0]) << FRAC);
			// lift-off repeats what was last reported
			if (!touch_now && touch_sent) begin
				px = sent_x;
				py = sent_y;
				tool = tool_sent;
			end
			if (pmx == pmn) pr = tra_pkg::PRESS_FULL;
			else pr = scale_axis(longint'($signed(pen_p_raw)) - pmn, pmx - pmn,
				longint'(tra_pkg::PRESS_FULL));
			if (touch_now || touch_sent) begin
				burst[n] = make_report(tra_pkg::KIND_PEN, tool, px, py, pr, touch_now, 1'b0);
				n++;
			end
			if (tool_sent != tra_pkg::TOOL_NONE && tool_now == tra_pkg::TOOL_NONE) begin
				burst[n] = make_report(tra_pkg::KIND_LEAVE, tool_now, 16'd0, 16'd0, 16'd0,
					1'b0, 1'b0);
				n++;
			end
			touch_sent = touch_now;
			tool_sent = tool_now;
			sent_x = px;
			sent_y = py;
			if (n > 0) burst[n-1].last = 1'b1;
			for (int i = 0; i < n; i++) pending_reports.push_back(burst[i]);
		end
		last_type = et;
		return n;
	endfunction

	function automatic step_t row(logic [4:0] et, logic [9:0] ec, logic [31:0] ev,
			bit typed = 1'b0, logic [1:0] cnt = 2'd0, report_t first = '0);
		step_t s;
		s.et = et;
		s.ec = ec;
		s.ev = ev;
		s.typed = typed;
		s.cnt = cnt;
		s.first = first;
		return s;
	endfunction

	// axis reading, mostly inside the configured range, sometimes just past it or random
	function automatic logic [31:0] axis_value(logic [2:0] min_idx, logic [2:0] max_idx);
		longint a, b, lo, span;
		int     pick;
		a = longint'($signed(cfg_reg[min_idx]));
		b = longint'($signed(cfg_reg[max_idx]));
		lo = (a < b) ? a : b;
		span = (a < b) ? b - a : a - b;
		pick = $urandom_range(19);
		if (pick < 14) return 32'(lo + longint'($urandom_range(32'(span))));
		if (pick < 16) return 32'(lo - 4 + longint'($urandom_range(8)));
		if (pick < 18) return 32'(lo + span - 4 + longint'($urandom_range(8)));
		return $urandom;
	endfunction

	function automatic logic [31:0] key_value();
		logic [31:0] v;
		if ($urandom_range(2) == 0) return 32'd0;
		v = $urandom;
		return (v == 0) ? 32'd1 : v;
	endfunction

	// present one event word, hold it until taken, then predict
	task automatic send_event(logic [4:0] et, logic [9:0] ec, logic [31:0] ev, output int n);
		int gap;
		gap = 0;
		while (gap < 60 && $urandom_range(99) < send_idle_pct) gap++;
		@(negedge clk);
		if (gap > 0) begin
			event_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		event_valid <= 1'b1;
		event_type <= et;
		event_code <= ec;
		event_value <= ev;
		@(posedge clk);
		while (!event_ready) @(posedge clk);
		n = assemble_reports(et, ec, ev);
	endtask

	// drop valid, wait for every queued report, then let the block settle
	task automatic drain_reports();
		@(negedge clk);
		event_valid <= 1'b0;
		while (pending_reports.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0000, val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg_reg[idx] = val;
	endtask

	// mostly well-formed frames ending in a sync, with some noise and broken words
	task automatic random_phase(int items);
		int         sent, n, pick;
		logic [9:0] tcode;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(9);
			if (pick < 7) begin
				if ($urandom_range(9) < 6) begin
					send_event(tra_pkg::EV_ABS, tra_pkg::CODE_ABS_X,
						axis_value(tra_pkg::REG_X_MIN, tra_pkg::REG_X_MAX), n);
					sent++;
				end
				if ($urandom_range(9) < 6) begin
					send_event(tra_pkg::EV_ABS, tra_pkg::CODE_ABS_Y,
						axis_value(tra_pkg::REG_Y_MIN, tra_pkg::REG_Y_MAX), n);
					sent++;
				end
				if ($urandom_range(9) < 6) begin
					send_event(tra_pkg::EV_ABS, tra_pkg::CODE_ABS_PRESSURE,
						axis_value(tra_pkg::REG_P_MIN, tra_pkg::REG_P_MAX), n);
					sent++;
				end
				if ($urandom_range(9) < 4) begin
					send_event(tra_pkg::EV_KEY, tra_pkg::CODE_BTN_TOUCH, key_value(), n);
					sent++;
				end
				if ($urandom_range(9) < 3) begin
					tcode = $urandom_range(1) ? tra_pkg::CODE_BTN_TOOL_PEN :
						tra_pkg::CODE_BTN_TOOL_RUBBER;
					send_event(tra_pkg::EV_KEY, tcode, key_value(), n);
					sent++;
				end
				send_event(tra_pkg::EV_SYN, tra_pkg::CODE_SYN_REPORT, $urandom, n);
				sent++;
				// a repeated sync is dropped by the block
				if ($urandom_range(9) == 0) begin
					send_event(tra_pkg::EV_SYN, tra_pkg::CODE_SYN_REPORT, $urandom, n);
					sent++;
				end
			end else if (pick == 7) begin
				send_event(5'($urandom), 10'($urandom), $urandom, n);
				sent++;
			end else if (pick == 8) begin
				case ($urandom_range(2))
					0: send_event(tra_pkg::EV_SYN, 10'($urandom_range(1, 1023)), $urandom, n);
					1: send_event(tra_pkg::EV_ABS, 10'($urandom), $urandom, n);
					default: send_event(tra_pkg::EV_KEY, 10'($urandom), $urandom, n);
				endcase
				sent++;
			end else begin
				send_event(tra_pkg::EV_SYN, tra_pkg::CODE_SYN_REPORT, $urandom, n);
				sent++;
			end
		end
	endtask

	// receiver stalls at the rate of the current phase
	always @(negedge clk) begin
		report_ready <= ($urandom_range(99) >= stall_pct);
	end

	// compare each taken report word with the oldest prediction
	always @(posedge clk) begin : watch_reports
		report_t want;
		if (arst_n && report_valid && report_ready) begin
			if (pending_reports.size() == 0) begin
				note_mismatch("report with none pending", 64'd0, 64'd1);
			end else begin
				want = pending_reports.pop_front();
				if (report_kind != want.kind)
					note_mismatch("report_kind", 64'(want.kind), 64'(report_kind));
				if (tool_kind != want.tool)
					note_mismatch("tool_kind", 64'(want.tool), 64'(tool_kind));
				if (pos_x != want.x) note_mismatch("pos_x", 64'(want.x), 64'(pos_x));
				if (pos_y != want.y) note_mismatch("pos_y", 64'(want.y), 64'(pos_y));
				if (pressure_level != want.press)
					note_mismatch("pressure_level", 64'(want.press), 64'(pressure_level));
				if (button_down != want.down)
					note_mismatch("button_down", 64'(want.down), 64'(button_down));
				if (last_of_run != want.last)
					note_mismatch("last_of_run", 64'(want.last), 64'(last_of_run));
			end
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : run
		int    n;
		step_t s;
		step_t directed_steps [$];
		arst_n = 1'b0;
		event_valid = 1'b0;
		event_type = '0;
		event_code = '0;
		event_value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_reg[tra_pkg::REG_X_MIN] = tra_pkg::X_MIN_RST;
		cfg_reg[tra_pkg::REG_X_MAX] = tra_pkg::X_MAX_RST;
		cfg_reg[tra_pkg::REG_Y_MIN] = tra_pkg::Y_MIN_RST;
		cfg_reg[tra_pkg::REG_Y_MAX] = tra_pkg::Y_MAX_RST;
		cfg_reg[tra_pkg::REG_P_MIN] = tra_pkg::P_MIN_RST;
		cfg_reg[tra_pkg::REG_P_MAX] = tra_pkg::P_MAX_RST;
		cfg_reg[tra_pkg::REG_SCR_W] = {4'h0, tra_pkg::SCR_W_RST};
		cfg_reg[tra_pkg::REG_SCR_H] = {4'h0, tra_pkg::SCR_H_RST};
		pen_x_raw = '0;
		pen_y_raw = '0;
		pen_p_raw = '0;
		touch_now = 1'b0;
		touch_sent = 1'b0;
		tool_now = tra_pkg::TOOL_NONE;
		tool_sent = tra_pkg::TOOL_NONE;
		sent_x = '0;
		sent_y = '0;
		last_type = tra_pkg::PREV_TYPE_RST;

		// directed words at the reset setting
		directed_steps.push_back(row(tra_pkg::EV_SYN, tra_pkg::CODE_SYN_REPORT, 32'd0,
			1'b1, 2'd0));
		directed_steps.push_back(row(tra_pkg::EV_SYN, tra_pkg::CODE_SYN_REPORT, 32'hFFFFFFFF,
			1'b1, 2'd0));
		directed_steps.push_back(row(tra_pkg::EV_SYN, CODE_UNUSED, 32'd0));
		directed_steps.push_back(row(tra_pkg::EV_KEY, tra_pkg::CODE_BTN_TOOL_PEN, 32'd1));
		directed_steps.push_back(row(tra_pkg::EV_ABS, tra_pkg::CODE_ABS_X, 32'd0));
		directed_steps.push_back(row(tra_pkg::EV_ABS, tra_pkg::CODE_ABS_Y, 32'd15725));
		directed_steps.push_back(row(tra_pkg::EV_ABS, tra_pkg::CODE_ABS_PRESSURE, 32'd4095));
		directed_steps.push_back(row(tra_pkg::EV_KEY, tra_pkg::CODE_BTN_TOUCH, 32'd1));
		directed_steps.push_back(row(tra_pkg::EV_SYN, tra_pkg::CODE_SYN_REPORT, 32'd0,
			1'b1, 2'd2, make_report(tra_pkg::KIND_ENTER, tra_pkg::TOOL_PEN,
			16'd0, 16'd0, 16'd0, 1'b0, 1'b0)));
		directed_steps.push_back(row(tra_pkg::EV_ABS, tra_pkg::CODE_ABS_X, 32'h7FFFFFFF));
		directed_steps.push_back(row(tra_pkg::EV_ABS, tra_pkg::CODE_ABS_Y, 32'h80000000));
		directed_steps.push_back(row(tra_pkg::EV_ABS, tra_pkg::CODE_ABS_PRESSURE,
			32'hFFFFFFFB));
		directed_steps.push_back(row(tra_pkg::EV_SYN, tra_pkg::CODE_SYN_REPORT, 32'd0,
			1'b1, 2'd1, make_report(tra_pkg::KIND_PEN, tra_pkg::TOOL_PEN,
			16'd22464, 16'd0, 16'd0, 1'b1, 1'b1)));
		directed_steps.push_back(row(tra_pkg::EV_KEY, tra_pkg::CODE_BTN_TOUCH, 32'd0));
		directed_steps.push_back(row(tra_pkg::EV_ABS, tra_pkg::CODE_ABS_X, 32'd100));
		directed_steps.push_back(row(tra_pkg::EV_SYN, tra_pkg::CODE_SYN_REPORT, 32'd0));
		directed_steps.push_back(row(tra_pkg::EV_SYN, tra_pkg::CODE_SYN_REPORT, 32'd0,
			1'b1, 2'd0));
		directed_steps.push_back(row(tra_pkg::EV_KEY, tra_pkg::CODE_BTN_TOOL_RUBBER,
			32'h80000000));
		directed_steps.push_back(row(EV_OTHER, tra_pkg::CODE_SYN_REPORT, 32'd5));
		directed_steps.push_back(row(tra_pkg::EV_KEY, CODE_UNUSED, 32'd1));
		directed_steps.push_back(row(tra_pkg::EV_ABS, CODE_ABS_DISTANCE, 32'd7));
		directed_steps.push_back(row(tra_pkg::EV_SYN, tra_pkg::CODE_SYN_REPORT, 32'd0,
			1'b1, 2'd0));
		directed_steps.push_back(row(tra_pkg::EV_KEY, tra_pkg::CODE_BTN_TOOL_RUBBER, 32'd0));
		directed_steps.push_back(row(tra_pkg::EV_SYN, tra_pkg::CODE_SYN_REPORT, 32'd0,
			1'b1, 2'd1, make_report(tra_pkg::KIND_LEAVE, tra_pkg::TOOL_NONE,
			16'd0, 16'd0, 16'd0, 1'b0, 1'b1)));
		directed_steps.push_back(row(EV_TOP, CODE_UNUSED, 32'hFFFFFFFF));
		directed_steps.push_back(row(tra_pkg::EV_KEY, tra_pkg::CODE_BTN_TOUCH, 32'd5));
		directed_steps.push_back(row(tra_pkg::EV_SYN, tra_pkg::CODE_SYN_REPORT, 32'd0));

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_steps[i]) begin
			s = directed_steps[i];
			send_event(s.et, s.ec, s.ev, n);
			if (s.typed) begin
				if (n != int'(s.cnt))
					note_mismatch("directed report count", 64'(s.cnt), 64'(n));
				else if (n > 0 && burst[0] != s.first)
					note_mismatch("directed first report", 64'(s.first), 64'(burst[0]));
			end
		end
		drain_reports();

		for (int phase = 0; phase < 4; phase++) begin
			// reload the registers while the block is idle
			case (phase)
				1: begin
					write_reg(tra_pkg::REG_X_MIN, 16'h8000);
					write_reg(tra_pkg::REG_X_MAX, 16'h7FFF);
					write_reg(tra_pkg::REG_Y_MIN, 16'h7FFF);
					write_reg(tra_pkg::REG_Y_MAX, 16'h8000);
					write_reg(tra_pkg::REG_P_MIN, 16'h8000);
					write_reg(tra_pkg::REG_P_MAX, 16'h8000);
					write_reg(tra_pkg::REG_SCR_W, 16'd4095);
					write_reg(tra_pkg::REG_SCR_H, 16'd1);
				end
				2: begin
					write_reg(tra_pkg::REG_X_MIN, 16'($urandom));
					write_reg(tra_pkg::REG_X_MAX, 16'($urandom));
					write_reg(tra_pkg::REG_Y_MIN, 16'($urandom));
					write_reg(tra_pkg::REG_Y_MAX, 16'($urandom));
					write_reg(tra_pkg::REG_P_MIN, 16'($urandom));
					write_reg(tra_pkg::REG_P_MAX, 16'($urandom));
					write_reg(tra_pkg::REG_SCR_W, 16'($urandom_range(1, 4095)));
					write_reg(tra_pkg::REG_SCR_H, 16'($urandom_range(1, 4095)));
				end
				3: begin
					write_reg(tra_pkg::REG_X_MIN, 16'd100);
					write_reg(tra_pkg::REG_X_MAX, 16'd100);
					write_reg(tra_pkg::REG_Y_MIN, 16'hFF00);
					write_reg(tra_pkg::REG_Y_MAX, 16'd300);
					write_reg(tra_pkg::REG_P_MIN, 16'h7FFF);
					write_reg(tra_pkg::REG_P_MAX, 16'h8000);
					write_reg(tra_pkg::REG_SCR_W, 16'd1);
					write_reg(tra_pkg::REG_SCR_H, 16'd4095);
				end
				default: ;
			endcase
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 86;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 86;
				end
				default: begin
					send_idle_pct = 11;
					stall_pct = 11;
				end
			endcase
			random_phase(25);
			drain_reports();
		end

		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/tra_pkg.sv
rtl/tra_scale.sv
rtl/tablet_report_assembler.sv
dv/tablet_report_assembler_tb.sv
